// ----- rtl/dlbp_pkg.sv -----
`timescale 1ns / 1ps

package dlbp_pkg;

   // default width of the size accumulator and payload counter
   localparam int SIZE_BITS_DEFAULT = 30;

   // fixed widths of the result fields
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int CODE_W  = 2;
   localparam int BSIZE_W = 30;

   // framing characters
   localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'd57;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [CODE_W-1:0] ERR_BAD_START = 2'd0;
   localparam logic [CODE_W-1:0] ERR_BAD_COUNT = 2'd1;
   localparam logic [CODE_W-1:0] ERR_BAD_DIGIT = 2'd2;
   localparam logic [CODE_W-1:0] ERR_BAD_END   = 2'd3;

   // deframer phases
   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_COUNT = 3'd1,
      PH_SIZE  = 3'd2,
      PH_DATA  = 3'd3,
      PH_END   = 3'd4
   } phase_type;

   // one result transaction
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last_payload;
      logic [BSIZE_W-1:0] block_size;
      logic [CODE_W-1:0]  error_code;
   } result_type;

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

endpackage

// ----- rtl/dlbp_in_stage.sv -----
`timescale 1ns / 1ps

module dlbp_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dlbp_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        advance,
   output logic                        byte_valid,
   output logic [dlbp_pkg::BYTE_W-1:0] byte_data
);
   import dlbp_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              load;

   // hold the byte until the framer consumes it
   always_comb begin
      req_stall = valid_ff && !advance;
      load      = req_valid && !req_stall;
      valid_in  = load ? 1'b1 : (advance ? 1'b0 : valid_ff);
      byte_in   = load ? req_in_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

// ----- rtl/dlbp_framer.sv -----
`timescale 1ns / 1ps

module dlbp_framer #(
   parameter int SIZE_BITS = dlbp_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [dlbp_pkg::BYTE_W-1:0] byte_data,
   output logic                        res_valid,
   output dlbp_pkg::result_type        res
);
   import dlbp_pkg::*;

   localparam int ACC_W = SIZE_BITS + 4;

   phase_type            phase_ff, phase_in;
   logic [3:0]           digits_ff, digits_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;

   logic [BYTE_W-1:0]    diff;
   logic [3:0]           digit;
   logic [3:0]           digits_dec;
   logic [ACC_W-1:0]     acc_wide;
   logic [SIZE_BITS-1:0] acc_sat;
   logic [SIZE_BITS-1:0] left_dec;
   logic [BSIZE_W-1:0]   size_out;

   // digit value and saturating size * 10 + digit
   always_comb begin
      diff       = byte_data - CHAR_ZERO;
      digit      = diff[3:0];
      digits_dec = digits_ff - 4'd1;
      acc_wide   = ({4'b0, size_ff} << 3) + ({4'b0, size_ff} << 1)
                 + {{(ACC_W-4){1'b0}}, digit};
      acc_sat    = (|acc_wide[ACC_W-1:SIZE_BITS]) ? {SIZE_BITS{1'b1}}
                                                  : acc_wide[SIZE_BITS-1:0];
      left_dec   = left_ff - {{(SIZE_BITS-1){1'b0}}, 1'b1};
   end

   // fit the decoded size to the result field
   generate
      if (SIZE_BITS >= BSIZE_W) begin : g_trunc
         assign size_out = size_ff[BSIZE_W-1:0];
      end else begin : g_ext
         assign size_out = {{(BSIZE_W-SIZE_BITS){1'b0}}, size_ff};
      end
   endgenerate

   // next state and result for the current byte
   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      size_in   = size_ff;
      left_in   = left_ff;
      res_valid = 1'b0;
      res       = '0;
      unique case (phase_ff)
         PH_COUNT: begin
            if (!is_digit(byte_data)) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_COUNT;
               phase_in       = PH_HUNT;
               digits_in      = '0;
               size_in        = '0;
               left_in        = '0;
            end else begin
               size_in   = '0;
               digits_in = digit;
               if (digit == 4'd0) begin
                  left_in  = '0;
                  phase_in = PH_END;
               end else begin
                  phase_in = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            if (!is_digit(byte_data)) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_DIGIT;
               phase_in       = PH_HUNT;
               digits_in      = '0;
               size_in        = '0;
               left_in        = '0;
            end else begin
               size_in   = acc_sat;
               digits_in = digits_dec;
               if (digits_dec == 4'd0) begin
                  left_in  = acc_sat;
                  phase_in = (acc_sat == '0) ? PH_END : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            left_in          = left_dec;
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = byte_data;
            res.last_payload = (left_dec == '0);
            if (left_dec == '0) begin
               phase_in = PH_END;
            end
         end
         PH_END: begin
            res_valid = 1'b1;
            phase_in  = PH_HUNT;
            digits_in = '0;
            size_in   = '0;
            left_in   = '0;
            if (byte_data != CHAR_NEWLINE) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_END;
            end else begin
               res.kind       = KIND_DONE;
               res.block_size = size_out;
            end
         end
         default: begin
            // hunting, unused codes included
            phase_in  = PH_HUNT;
            digits_in = '0;
            size_in   = '0;
            left_in   = '0;
            if (byte_data != CHAR_HASH) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_START;
            end else begin
               phase_in = PH_COUNT;
            end
         end
      endcase
   end

   // state registers advance once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         digits_ff <= '0;
         size_ff   <= '0;
         left_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         size_ff   <= size_in;
         left_ff   <= left_in;
      end
   end

endmodule

// ----- rtl/dlbp_out_stage.sv -----
`timescale 1ns / 1ps

module dlbp_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_valid,
   input  logic                         res_valid,
   input  dlbp_pkg::result_type         res,
   output logic                         advance,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dlbp_pkg::KIND_W-1:0]  rsp_kind,
   output logic [dlbp_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                         rsp_last_payload,
   output logic [dlbp_pkg::BSIZE_W-1:0] rsp_block_size,
   output logic [dlbp_pkg::CODE_W-1:0]  rsp_error_code
);
   import dlbp_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;
   logic       load;

   // the framer moves on whenever the result slot is free or draining
   always_comb begin
      advance  = byte_valid && (!valid_ff || !rsp_stall);
      load     = advance && res_valid;
      valid_in = load ? 1'b1 : ((valid_ff && !rsp_stall) ? 1'b0 : valid_ff);
      res_in   = load ? res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = res_ff.kind;
   assign rsp_payload_byte = res_ff.payload_byte;
   assign rsp_last_payload = res_ff.last_payload;
   assign rsp_block_size   = res_ff.block_size;
   assign rsp_error_code   = res_ff.error_code;

endmodule

// ----- rtl/definite_length_block_parser.sv -----
`timescale 1ns / 1ps

// Deframes definite-length arbitrary blocks from a byte stream: '#', one digit N,
// N decimal size digits, the payload and a closing newline. Each payload byte comes
// out as a payload transaction (the final one flagged), the newline gives a done
// transaction with the decoded size, and any framing violation gives an error
// transaction and a return to hunting for '#'. One byte is taken per cycle while
// req_stall is low; a byte is held in the input register and its result is then
// registered in the result register, from which it is offered to the consumer. The
// byte rate is set by the single framer state update, and rsp_stall back-pressures
// req_stall in the same cycle. Size digits beyond the accumulator range saturate at
// 2^SIZE_BITS - 1.
module definite_length_block_parser #(
   parameter int SIZE_BITS = dlbp_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dlbp_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dlbp_pkg::KIND_W-1:0]  rsp_kind,
   output logic [dlbp_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                         rsp_last_payload,
   output logic [dlbp_pkg::BSIZE_W-1:0] rsp_block_size,
   output logic [dlbp_pkg::CODE_W-1:0]  rsp_error_code
);
   import dlbp_pkg::*;

   logic              advance;
   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              res_valid;
   result_type        res;

   // input register
   dlbp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   // framing state machine
   dlbp_framer #(
      .SIZE_BITS (SIZE_BITS)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   dlbp_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (byte_valid),
      .res_valid        (res_valid),
      .res              (res),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last_payload (rsp_last_payload),
      .rsp_block_size   (rsp_block_size),
      .rsp_error_code   (rsp_error_code)
   );

endmodule
